// ----- hdl/tost_pkg.sv -----
package tost_pkg;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 104;
    localparam int PAYLOAD_W   = 64;
    localparam int STRING_W    = 32;

    localparam logic [1:0] CMD_EFFECT   = 2'd0;
    localparam logic [1:0] CMD_PUSH_INT = 2'd1;
    localparam logic [1:0] CMD_PUSH_STR = 2'd2;

    localparam logic [1:0] KIND_ABSENT  = 2'd0;
    localparam logic [1:0] KIND_UNKNOWN = 2'd1;
    localparam logic [1:0] KIND_INT     = 2'd2;
    localparam logic [1:0] KIND_STR     = 2'd3;

    typedef struct packed {
        logic [1:0]           tag;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

endpackage

// ----- hdl/typed_operand_stack_tracker_unit.sv -----
// A push, or an effect after its pops, writes entries while there is room; an insert shifts
// the entries above its point up and writes the new one; an ignored or full insert or an
// unused command writes nothing. Each item then reads its query and loads the result; a held
// result stalls the next item. One item at a time, the next beat taken in the cycle after
// the result loads; one stack memory write and one read port serve each push, move and query.
// Reset (aresetn low, synchronous) empties the stack and drops any pending result.
module typed_operand_stack_tracker_unit #(
    parameter int DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pop_count, push_count, insert_mode, insert_depth, int_value, string_id,
    // query_depth, zero pad
    input  logic [tost_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // query_int, query_string, entry_count, overflow, zero pad
    output logic [tost_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // query_kind
    output logic [1:0]                         m_axis_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PUSH     = 7'b0000010,
        ST_SHIFT_RD = 7'b0000100,
        ST_SHIFT_WR = 7'b0001000,
        ST_INS_WR   = 7'b0010000,
        ST_QUERY    = 7'b0100000,
        ST_OUT      = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    tost_pkg::entry_t  wdata_reg, wdata_next;
    logic [3:0]        qdepth_reg, qdepth_next;
    logic              hit_reg, hit_next;
    logic              ovf_reg, ovf_next;
    logic              m_valid_reg, m_valid_next;
    logic [tost_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    logic [4:0]        in_pop_count;
    logic [4:0]        in_push_count;
    logic              in_insert_mode;
    logic [3:0]        in_insert_depth;
    logic [63:0]       in_int_value;
    logic [31:0]       in_string_id;
    logic [3:0]        in_query_depth;

    logic              in_accept;
    logic              out_load;
    logic [XW-1:0]     occ_x;
    logic [XW-1:0]     pops_x;
    logic [XW-1:0]     qaddr_x;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    tost_pkg::entry_t  ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    tost_pkg::entry_t  ram_rd_data;

    logic [1:0]        res_kind;
    logic [63:0]       res_int;
    logic [31:0]       res_str;

    assign in_pop_count    = s_axis_tdata[4:0];
    assign in_push_count   = s_axis_tdata[9:5];
    assign in_insert_mode  = s_axis_tdata[10];
    assign in_insert_depth = s_axis_tdata[14:11];
    assign in_int_value    = s_axis_tdata[78:15];
    assign in_string_id    = s_axis_tdata[110:79];
    assign in_query_depth  = s_axis_tdata[114:111];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign occ_x         = XW'(occ_reg);
    assign pops_x        = XW'(in_pop_count);
    assign qaddr_x       = occ_x - XW'(1) - XW'(qdepth_reg);

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        wdata_next   = wdata_reg;
        qdepth_next  = qdepth_reg;
        hit_next     = hit_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        out_load     = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = ptr_reg;
        ram_wr_data  = wdata_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = ptr_reg - AW'(1);

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    ovf_next    = 1'b0;
                    qdepth_next = in_query_depth;
                    cnt_next    = 5'd1;
                    state_next  = ST_PUSH;
                    case (s_axis_tuser)
                        tost_pkg::CMD_EFFECT: begin
                            wdata_next = '{tag: tost_pkg::KIND_UNKNOWN, payload: '0};
                            if (!in_insert_mode) begin
                                occ_next = (occ_x > pops_x) ? CW'(occ_x - pops_x) : '0;
                                cnt_next = in_push_count;
                            end else if (XW'(in_insert_depth) < occ_x) begin
                                if (occ_x == XW'(DEPTH)) begin
                                    ovf_next   = 1'b1;
                                    state_next = ST_QUERY;
                                end else begin
                                    ptr_next   = occ_reg[AW-1:0];
                                    cnt_next   = 5'(in_insert_depth) + 5'd1;
                                    state_next = ST_SHIFT_RD;
                                end
                            end else begin
                                state_next = ST_QUERY;
                            end
                        end
                        tost_pkg::CMD_PUSH_INT: begin
                            wdata_next = '{tag: tost_pkg::KIND_INT, payload: in_int_value};
                        end
                        tost_pkg::CMD_PUSH_STR: begin
                            wdata_next = '{tag: tost_pkg::KIND_STR,
                                           payload: 64'(in_string_id)};
                        end
                        default: begin
                            state_next = ST_QUERY;
                        end
                    endcase
                end
            end
            ST_PUSH: begin
                if (cnt_reg == 5'd0) begin
                    state_next = ST_QUERY;
                end else if (occ_x == XW'(DEPTH)) begin
                    ovf_next   = 1'b1;
                    cnt_next   = 5'd0;
                    state_next = ST_QUERY;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = occ_reg[AW-1:0];
                    occ_next    = occ_reg + CW'(1);
                    cnt_next    = cnt_reg - 5'd1;
                end
            end
            ST_SHIFT_RD: begin
                ram_rd_en  = 1'b1;
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data;
                ptr_next    = ptr_reg - AW'(1);
                cnt_next    = cnt_reg - 5'd1;
                state_next  = (cnt_reg == 5'd1) ? ST_INS_WR : ST_SHIFT_RD;
            end
            ST_INS_WR: begin
                ram_wr_en  = 1'b1;
                occ_next   = occ_reg + CW'(1);
                state_next = ST_QUERY;
            end
            ST_QUERY: begin
                hit_next    = XW'(qdepth_reg) < occ_x;
                ram_rd_en   = XW'(qdepth_reg) < occ_x;
                ram_rd_addr = qaddr_x[AW-1:0];
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res_kind = hit_reg ? ram_rd_data.tag : tost_pkg::KIND_ABSENT;
        res_int  = (res_kind == tost_pkg::KIND_INT) ? ram_rd_data.payload : '0;
        res_str  = (res_kind == tost_pkg::KIND_STR) ?
                   ram_rd_data.payload[tost_pkg::STRING_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            cnt_reg     <= '0;
            ptr_reg     <= '0;
            hit_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            cnt_reg     <= cnt_next;
            ptr_reg     <= ptr_next;
            hit_reg     <= hit_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wdata_reg  <= wdata_next;
        qdepth_reg <= qdepth_next;
        if (out_load) begin
            m_tdata_reg <= {2'b00, ovf_reg, occ_x[4:0], res_str, res_int};
            m_tuser_reg <= res_kind;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    tost_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_x <= XW'(DEPTH))
        else $error("occupancy beyond depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_axis_tready)
        else $error("ready right after accept");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (occ_x < XW'(DEPTH)))
        else $error("stack write on full stack");

    a_write_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && (state_reg != ST_SHIFT_WR)) |->
            (ram_wr_data.tag != tost_pkg::KIND_ABSENT))
        else $error("absent tag written");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output step");
`endif

endmodule

// ----- hdl/tost_ram.sv -----
module tost_ram #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tost_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output tost_pkg::entry_t rd_data
);

    tost_pkg::entry_t mem [DEPTH];
    tost_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- test/typed_operand_stack_tracker_unit_tb.sv -----
module typed_operand_stack_tracker_unit_tb;

    localparam int          STACK_DEPTH = 16;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE_CYCLES = 48;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  pop_count;
        logic [4:0]  push_count;
        logic        insert_mode;
        logic [3:0]  insert_depth;
        logic [63:0] int_value;
        logic [31:0] string_id;
        logic [3:0]  query_depth;
    } stack_op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] query_int;
        logic [31:0] query_string;
        logic [4:0]  entry_count;
        logic        overflow;
    } stack_report_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // pop_count, push_count, insert_mode, insert_depth, int_value, string_id,
    // query_depth, zero pad
    logic [tost_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // command
    logic [1:0]              s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // query_int, query_string, entry_count, overflow, zero pad
    logic [tost_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    // query_kind
    logic [1:0]              m_axis_tuser;

    logic [1:0]              stk_kind [STACK_DEPTH];
    logic [63:0]             stk_value [STACK_DEPTH];
    int                      stk_fill = 0;

    stack_report_t           pending_reports [$];
    int                      error_count = 0;
    int                      items_sent = 0;
    int                      reports_checked = 0;
    int                      overflow_reports = 0;
    int                      cycle_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      holdoff_left = 0;

    typed_operand_stack_tracker_unit #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL typed_operand_stack_tracker_unit");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (holdoff_left > 0) begin
            m_axis_tready <= 1'b0;
            holdoff_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic stack_report_t apply_stack_item(stack_op_t op);
        stack_report_t rep;
        int            pos;
        int            idx;
        rep = '0;
        case (op.command)
            tost_pkg::CMD_EFFECT: begin
                if (op.insert_mode) begin
                    if (int'(op.insert_depth) < stk_fill) begin
                        if (stk_fill >= STACK_DEPTH) begin
                            rep.overflow = 1'b1;
                        end else begin
                            pos = stk_fill - 1 - int'(op.insert_depth);
                            for (int i = stk_fill; i > pos; i--) begin
                                stk_kind[i]  = stk_kind[i-1];
                                stk_value[i] = stk_value[i-1];
                            end
                            stk_kind[pos]  = tost_pkg::KIND_UNKNOWN;
                            stk_value[pos] = '0;
                            stk_fill++;
                        end
                    end
                end else begin
                    for (int i = 0; i < op.pop_count; i++)
                        if (stk_fill > 0) stk_fill--;
                    for (int i = 0; i < op.push_count; i++) begin
                        if (stk_fill < STACK_DEPTH) begin
                            stk_kind[stk_fill]  = tost_pkg::KIND_UNKNOWN;
                            stk_value[stk_fill] = '0;
                            stk_fill++;
                        end else begin
                            rep.overflow = 1'b1;
                        end
                    end
                end
            end
            tost_pkg::CMD_PUSH_INT, tost_pkg::CMD_PUSH_STR: begin
                if (stk_fill < STACK_DEPTH) begin
                    stk_kind[stk_fill]  = (op.command == tost_pkg::CMD_PUSH_INT) ?
                                          tost_pkg::KIND_INT : tost_pkg::KIND_STR;
                    stk_value[stk_fill] = (op.command == tost_pkg::CMD_PUSH_INT) ?
                                          op.int_value : {32'b0, op.string_id};
                    stk_fill++;
                end else begin
                    rep.overflow = 1'b1;
                end
            end
            default: ;
        endcase
        rep.kind = tost_pkg::KIND_ABSENT;
        if (int'(op.query_depth) < stk_fill) begin
            idx = stk_fill - 1 - int'(op.query_depth);
            rep.kind = stk_kind[idx];
            if (rep.kind == tost_pkg::KIND_INT) rep.query_int = stk_value[idx];
            if (rep.kind == tost_pkg::KIND_STR) rep.query_string = stk_value[idx][31:0];
        end
        rep.entry_count = stk_fill[4:0];
        return rep;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    task automatic check_report();
        stack_report_t exp_rep;
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result beat tdata %h tuser %h", $time,
                     m_axis_tdata, m_axis_tuser);
            error_count++;
        end else begin
            exp_rep = pending_reports.pop_front();
            check_field("query_kind", 64'(exp_rep.kind), 64'(m_axis_tuser));
            check_field("query_int", exp_rep.query_int, m_axis_tdata[63:0]);
            check_field("query_string", 64'(exp_rep.query_string),
                        64'(m_axis_tdata[95:64]));
            check_field("entry_count", 64'(exp_rep.entry_count),
                        64'(m_axis_tdata[100:96]));
            check_field("overflow", 64'(exp_rep.overflow), 64'(m_axis_tdata[101]));
            if (exp_rep.overflow) overflow_reports++;
            reports_checked++;
        end
    endtask

    always @(posedge aclk) begin : beat_monitor
        stack_op_t seen_op;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) check_report();
            if (s_axis_tvalid && s_axis_tready) begin
                seen_op.command      = s_axis_tuser;
                seen_op.pop_count    = s_axis_tdata[4:0];
                seen_op.push_count   = s_axis_tdata[9:5];
                seen_op.insert_mode  = s_axis_tdata[10];
                seen_op.insert_depth = s_axis_tdata[14:11];
                seen_op.int_value    = s_axis_tdata[78:15];
                seen_op.string_id    = s_axis_tdata[110:79];
                seen_op.query_depth  = s_axis_tdata[114:111];
                pending_reports.insert(pending_reports.size(), apply_stack_item(seen_op));
                items_sent++;
            end
        end
    end

    task automatic send_op(stack_op_t op);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op.command;
        s_axis_tdata  <= {5'b0, op.query_depth, op.string_id, op.int_value,
                          op.insert_depth, op.insert_mode, op.push_count, op.pop_count};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_fields(logic [1:0] cmd, logic [4:0] pops, logic [4:0] pushes,
                               logic mode, logic [3:0] ins_depth, logic [63:0] ival,
                               logic [31:0] sid, logic [3:0] qdepth);
        stack_op_t op;
        op = '{cmd, pops, pushes, mode, ins_depth, ival, sid, qdepth};
        send_op(op);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    function automatic stack_op_t random_stack_op();
        stack_op_t op;
        int        sel;
        sel = $urandom_range(99);
        op.command = (sel < 45) ? tost_pkg::CMD_EFFECT : (sel < 70) ? tost_pkg::CMD_PUSH_INT :
                     (sel < 94) ? tost_pkg::CMD_PUSH_STR : CMD_UNUSED;
        op.pop_count  = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
                                                   5'($urandom_range(4));
        op.push_count = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
                                                   5'($urandom_range(3));
        op.insert_mode = ($urandom_range(2) == 0);
        op.insert_depth = (stk_fill > 0 && $urandom_range(3) != 0) ?
                          4'($urandom_range(stk_fill - 1)) : 4'($urandom_range(15));
        sel = $urandom_range(19);
        op.int_value = (sel == 0) ? 64'h8000_0000_0000_0000 :
                       (sel == 1) ? 64'h7FFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
        op.string_id = $urandom;
        op.query_depth = (stk_fill > 0 && $urandom_range(4) != 0) ?
                         4'($urandom_range(stk_fill - 1)) : 4'($urandom_range(15));
        return op;
    endfunction

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_fields(tost_pkg::CMD_EFFECT, 5'd0, 5'd0, 1'b0, 4'd0, 64'd0, 32'd0, 4'd0);
        send_fields(tost_pkg::CMD_EFFECT, 5'd31, 5'd0, 1'b0, 4'd0, '1, '1, 4'd0);
        send_fields(tost_pkg::CMD_PUSH_INT, 5'd0, 5'd0, 1'b0, 4'd0,
                    64'h8000_0000_0000_0000, 32'd0, 4'd0);
        send_fields(tost_pkg::CMD_PUSH_INT, 5'd0, 5'd0, 1'b0, 4'd0,
                    64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 4'd1);
        send_fields(tost_pkg::CMD_PUSH_STR, 5'd0, 5'd0, 1'b0, 4'd0, 64'd0,
                    32'h0000_0000, 4'd0);
        send_fields(tost_pkg::CMD_PUSH_STR, 5'd0, 5'd0, 1'b0, 4'd0, 64'd0,
                    32'hFFFF_FFFF, 4'd0);
        send_fields(CMD_UNUSED, 5'd31, 5'd31, 1'b1, 4'd0, '1, '1, 4'd3);
        send_fields(tost_pkg::CMD_EFFECT, 5'd0, 5'd0, 1'b1, 4'd15, 64'd0, 32'd0, 4'd15);
        send_fields(tost_pkg::CMD_EFFECT, 5'd0, 5'd0, 1'b1, 4'd1, 64'd0, 32'd0, 4'd2);
        send_fields(tost_pkg::CMD_EFFECT, 5'd0, 5'd0, 1'b1, 4'd4, 64'd0, 32'd0, 4'd5);
        send_fields(tost_pkg::CMD_PUSH_INT, 5'd31, 5'd31, 1'b1, 4'd0,
                    64'h0123_4567_89AB_CDEF, 32'd0, 4'd0);
        send_fields(tost_pkg::CMD_EFFECT, 5'd0, 5'd31, 1'b0, 4'd0, 64'd0, 32'd0, 4'd15);
        send_fields(tost_pkg::CMD_PUSH_INT, 5'd0, 5'd0, 1'b0, 4'd0,
                    64'hDEAD_BEEF_0000_0001, 32'd0, 4'd0);
        send_fields(tost_pkg::CMD_PUSH_STR, 5'd0, 5'd0, 1'b0, 4'd0, 64'd0,
                    32'h1234_5678, 4'd0);
        send_fields(tost_pkg::CMD_EFFECT, 5'd0, 5'd0, 1'b1, 4'd15, 64'd0, 32'd0, 4'd15);
        send_fields(tost_pkg::CMD_EFFECT, 5'd0, 5'd0, 1'b1, 4'd0, 64'd0, 32'd0, 4'd0);
        send_fields(tost_pkg::CMD_EFFECT, 5'd1, 5'd1, 1'b0, 4'd0, 64'd0, 32'd0, 4'd14);
        send_fields(tost_pkg::CMD_EFFECT, 5'd16, 5'd0, 1'b0, 4'd0, 64'd0, 32'd0, 4'd0);
        send_fields(tost_pkg::CMD_EFFECT, 5'd0, 5'd16, 1'b0, 4'd0, 64'd0, 32'd0, 4'd15);
        send_fields(tost_pkg::CMD_EFFECT, 5'd31, 5'd31, 1'b0, 4'd0, 64'd0, 32'd0, 4'd7);
        send_fields(tost_pkg::CMD_EFFECT, 5'd31, 5'd0, 1'b0, 4'd0, 64'd0, 32'd0, 4'd0);
        send_fields(tost_pkg::CMD_PUSH_STR, 5'd0, 5'd0, 1'b0, 4'd15, 64'd0,
                    32'hA5A5_5A5A, 4'd15);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_op(random_stack_op());
    endtask

    task automatic test_full_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 300;
        repeat (30) send_op(random_stack_op());
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 10;
        recv_stall_pct = 30;
        repeat (10) send_op(random_stack_op());
        wait_for_drain();
        repeat (10) send_op(random_stack_op());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_traffic(400, 0, 0);
        test_random_traffic(400, 56, 0);
        test_random_traffic(400, 0, 56);
        test_random_traffic(400, 24, 24);
        test_full_backpressure();
        test_drain_pause();
        wait_for_drain();
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d stack items (directed edges, random mixes, stalls) with %0d results",
                 items_sent, reports_checked);
        $display("checked, %0d of them flagged overflow, %0d errors", overflow_reports,
                 error_count);
        if (error_count == 0) begin
            $display("PASS typed_operand_stack_tracker_unit");
        end else begin
            $display("FAIL typed_operand_stack_tracker_unit");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tost_pkg.sv
hdl/tost_ram.sv
hdl/typed_operand_stack_tracker_unit.sv
test/typed_operand_stack_tracker_unit_tb.sv
